@@ rtl/base64_stream_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// base64_stream_decoder_assert.svh
// assertion macros used by the base64 stream decoder rtl
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define B64SD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("base64 decoder check failed");

// next-cycle implication, checked outside reset
`define B64SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("base64 decoder check failed");

`endif

@@ rtl/b64sd_pkg.sv @@
// ----------------------------------------------------------------------------
// b64sd_pkg
// types, constants and the alphabet lookup for the base64 stream decoder
// ----------------------------------------------------------------------------
package b64sd_pkg;

  localparam logic [7:0]  EndMark    = 8'h3D;
  localparam logic [7:0]  NoSymbol   = 8'hFF;
  localparam logic [15:0] MaxLenRst  = 16'hFFFF;

  localparam logic [1:0] PhaseNone = 2'd0;
  localparam logic [1:0] PhaseSix  = 2'd1;
  localparam logic [1:0] PhaseFour = 2'd2;
  localparam logic [1:0] PhaseTwo  = 2'd3;

  typedef struct packed {
    logic [7:0] in_char;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        string_done;
    logic [15:0] total_len;
  } out_t;

  typedef struct packed {
    logic [1:0]  bit_phase;
    logic [7:0]  partial_byte;
    logic [15:0] byte_count;
    logic        halted;
  } state_t;

  // 6-bit value of an alphabet character, NoSymbol otherwise
  function automatic logic [7:0] symbol_value(input logic [7:0] c);
    logic [7:0] v;
    v = NoSymbol;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      v = 8'd62;
    end else if (c == 8'h2F) begin
      v = 8'd63;
    end
    return v;
  endfunction

endpackage

@@ rtl/b64sd_step.sv @@
// ----------------------------------------------------------------------------
// b64sd_step
// per-character decode: lookup, bit packing and string bookkeeping
// ----------------------------------------------------------------------------
module b64sd_step (
  input  b64sd_pkg::state_t state_i,
  input  b64sd_pkg::in_t    beat_i,
  input  logic [15:0]       max_out_len_i,
  output b64sd_pkg::state_t state_o,
  output b64sd_pkg::out_t   res_o,
  output logic              has_res_o
);

  logic [7:0]        sym;
  logic [5:0]        v;
  logic              active;
  logic              have_byte;
  logic [7:0]        byte_val;
  b64sd_pkg::state_t nxt;

  assign sym = b64sd_pkg::symbol_value(beat_i.in_char);
  assign v   = sym[5:0];
  assign active = !state_i.halted && (state_i.byte_count < max_out_len_i);

  always_comb begin
    nxt       = state_i;
    have_byte = 1'b0;
    byte_val  = 8'd0;
    if (active) begin
      if (beat_i.in_char == b64sd_pkg::EndMark) begin
        nxt.halted = 1'b1;
      end else if (sym != b64sd_pkg::NoSymbol) begin
        unique case (state_i.bit_phase)
          b64sd_pkg::PhaseNone: begin
            nxt.partial_byte = {v, 2'b00};
            nxt.bit_phase    = b64sd_pkg::PhaseSix;
          end
          b64sd_pkg::PhaseSix: begin
            byte_val         = state_i.partial_byte | {6'd0, v[5:4]};
            nxt.partial_byte = {v[3:0], 4'd0};
            nxt.bit_phase    = b64sd_pkg::PhaseFour;
            have_byte        = 1'b1;
          end
          b64sd_pkg::PhaseFour: begin
            byte_val         = state_i.partial_byte | {4'd0, v[5:2]};
            nxt.partial_byte = {v[1:0], 6'd0};
            nxt.bit_phase    = b64sd_pkg::PhaseTwo;
            have_byte        = 1'b1;
          end
          default: begin
            byte_val         = state_i.partial_byte | {2'd0, v};
            nxt.partial_byte = 8'd0;
            nxt.bit_phase    = b64sd_pkg::PhaseNone;
            have_byte        = 1'b1;
          end
        endcase
        if (have_byte) begin
          nxt.byte_count = state_i.byte_count + 16'd1;
        end
      end
    end
  end

  always_comb begin
    res_o.out_byte    = byte_val;
    res_o.byte_valid  = have_byte;
    res_o.string_done = beat_i.last_char;
    res_o.total_len   = nxt.byte_count;
    has_res_o         = have_byte || beat_i.last_char;
    // the last character clears everything for the next string
    state_o           = beat_i.last_char ? '0 : nxt;
  end

endmodule

@@ rtl/base64_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder
// streaming base64 decoder, one character per beat
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one character per beat with a last-character flag
//   out_* : zero or one result per character; a result is sent when a byte
//           completes or on the string's last character (string_done,
//           total_len then final)
//   cfg_* : writes max_out_len, the per-string output budget; write only
//           while no character is in flight
// timing:
//   input register, one stage of decode logic, output register; a result
//   moves from the input register through decode into the output register
//   one character per cycle unless a held result stalls it, set by the single decode stage
// reset:
//   string state cleared, max_out_len back to 65535, both registers empty
// stall:
//   a held result blocks the input register only when it has a result of
//   its own to deliver; characters with no result keep flowing
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_assert.svh"

module base64_stream_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  b64sd_pkg::in_t     in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output b64sd_pkg::out_t    out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  logic              s1_valid_r;
  b64sd_pkg::in_t    s1_data_r;
  b64sd_pkg::state_t state_r;
  b64sd_pkg::state_t state_nxt;
  logic [15:0]       max_out_len_r;
  logic              out_valid_r;
  b64sd_pkg::out_t   out_data_r;
  b64sd_pkg::out_t   res;
  logic              has_res;
  logic              out_free;
  logic              s1_fire;

  b64sd_step u_step (
    .state_i       (state_r),
    .beat_i        (s1_data_r),
    .max_out_len_i (max_out_len_r),
    .state_o       (state_nxt),
    .res_o         (res),
    .has_res_o     (has_res)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign s1_fire   = s1_valid_r && (!has_res || out_free);
  assign in_ready  = !s1_valid_r || s1_fire;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      state_r       <= '0;
      max_out_len_r <= b64sd_pkg::MaxLenRst;
    end else begin
      if (cfg_valid) begin
        max_out_len_r <= cfg_data;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_fire) begin
        state_r <= state_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_fire && has_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (out_free && s1_fire && has_res) begin
      out_data_r <= res;
    end
  end

  // string state is clear after the last character leaves decode
  `B64SD_ASSERT_NEXT(a_clear_after_last, clk, rst_n, s1_fire && s1_data_r.last_char, state_r == '0)
  // a delivered byte is always counted
  `B64SD_ASSERT_NOW(a_byte_counted, clk, rst_n, out_valid_r && out_data_r.byte_valid, out_data_r.total_len != 16'd0)
  // nothing decodes once the end marker has been seen
  `B64SD_ASSERT_NOW(a_halt_no_byte, clk, rst_n, s1_valid_r && state_r.halted, !res.byte_valid)
  // a result is never dropped while the output register is held
  `B64SD_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_r && !out_ready && s1_valid_r && has_res, !s1_fire)

endmodule
